// ===== rtl/fblf_pkg.sv =====
// ----------------------------------------------------------------------------
// fblf_pkg
// types and constants shared by the frame store span fill block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fblf_pkg;

	localparam int TYPE_W  = 3;
	localparam int X_W     = 10;
	localparam int Y_W     = 9;
	localparam int PIX_W   = 32;
	localparam int FW_W    = 11;
	localparam int FH_W    = 10;
	localparam int CFG_W   = 11;
	localparam int CIDX_W  = 1;
	// y*w+x never reaches 2^21 with these field widths
	localparam int LIN_W   = 21;

	localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_W-1:0] FH_RESET = 10'd512;

	localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
	localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

	localparam logic [TYPE_W-1:0] REQ_WRITE = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_READ  = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_HFILL = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_VFILL = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_HXOR  = 3'd4;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [X_W-1:0]    x_first;
		logic [X_W-1:0]    x_last;
		logic [Y_W-1:0]    y_first;
		logic [Y_W-1:0]    y_last;
		logic [PIX_W-1:0]  color;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] read_pixel;
		logic             status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic calc;
		logic mem_we;
		logic mem_re;
		logic xor_wr;
		logic cap_rd;
		logic step;
		logic clr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;
		logic is_read;
		logic is_xor;
		logic last;
		logic clr_last;
	} sts_t;

endpackage

// ===== rtl/framebuffer_line_fill.sv =====
// ----------------------------------------------------------------------------
// framebuffer_line_fill: frame store with pixel access and span fills
// sequence: a refused request goes from setup straight to the done beat, a pixel
// write writes then strobes done, a read issues then captures the store read
// order: the next start can be taken in the cycle after done; fills write one
// pixel a cycle, xor spans read then write each pixel
// reset: registers to 1024 x 512, then a sweep over all MAX_WIDTH*MAX_HEIGHT
// words zeroes the store with busy high; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framebuffer_line_fill #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request beat, taken when start is high and busy low
	input  logic                        start,
	output logic                        busy,
	input  fblf_pkg::req_t              req,
	// result beat, valid for the single cycle done is high
	output logic                        done,
	output fblf_pkg::rsp_t              rsp,
	// register write port, the user must write it only while idle; not enforced here
	input  logic                        cfg_we,
	input  logic [fblf_pkg::CIDX_W-1:0] cfg_index,
	input  logic [fblf_pkg::CFG_W-1:0]  cfg_data
);

	fblf_pkg::cmd_t cmd;
	fblf_pkg::sts_t sts;

	// sequencer: walks each request through setup, pixel steps and the result beat
	fblf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.sts   (sts)
	);

	// datapath: range check, row-major address math, span counter and store
	fblf_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/fblf_ram.sv =====
// ----------------------------------------------------------------------------
// fblf_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fblf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/fblf_ctrl.sv =====
// ----------------------------------------------------------------------------
// fblf_ctrl
// request sequencer: clear sweep, address setup, span walk, result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fblf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output fblf_pkg::cmd_t cmd,
	input  fblf_pkg::sts_t sts
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ADDR  = 4'd2;
	localparam logic [3:0] ST_WR    = 4'd3;
	localparam logic [3:0] ST_RD    = 4'd4;
	localparam logic [3:0] ST_RDW   = 4'd5;
	localparam logic [3:0] ST_XRD   = 4'd6;
	localparam logic [3:0] ST_XWR   = 4'd7;
	localparam logic [3:0] ST_RESP  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_ADDR;
				end
			end
			ST_ADDR: begin
				cmd.calc = 1'b1;
				if (sts.bad) state_nxt = ST_RESP;
				else if (sts.is_read) state_nxt = ST_RD;
				else if (sts.is_xor) state_nxt = ST_XRD;
				else state_nxt = ST_WR;
			end
			ST_WR: begin
				cmd.mem_we = 1'b1;
				cmd.step   = 1'b1;
				if (sts.last) state_nxt = ST_RESP;
			end
			ST_RD: begin
				cmd.mem_re = 1'b1;
				state_nxt  = ST_RDW;
			end
			ST_RDW: begin
				cmd.cap_rd = 1'b1;
				state_nxt  = ST_RESP;
			end
			ST_XRD: begin
				cmd.mem_re = 1'b1;
				state_nxt  = ST_XWR;
			end
			ST_XWR: begin
				cmd.xor_wr = 1'b1;
				cmd.step   = 1'b1;
				state_nxt  = sts.last ? ST_RESP : ST_XRD;
			end
			ST_RESP: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/fblf_datapath.sv =====
// ----------------------------------------------------------------------------
// fblf_datapath
// config registers, range check, address and span counters, pixel store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fblf_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fblf_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [fblf_pkg::CFG_W-1:0]    cfg_data,
	input  fblf_pkg::req_t                req,
	input  fblf_pkg::cmd_t                cmd,
	output fblf_pkg::sts_t                sts,
	output fblf_pkg::rsp_t                rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [fblf_pkg::FW_W-1:0]   fw_q;
	logic [fblf_pkg::FH_W-1:0]   fh_q;
	logic [fblf_pkg::FW_W-1:0]   eff_w;
	logic [fblf_pkg::FH_W-1:0]   eff_h;
	fblf_pkg::req_t              req_q;
	fblf_pkg::rsp_t              rsp_q;
	logic [AW-1:0]               addr_q;
	logic [AW-1:0]               clr_addr_q;
	logic [fblf_pkg::X_W-1:0]    cnt_q;
	logic [fblf_pkg::X_W-1:0]    span_cnt;
	logic [fblf_pkg::LIN_W-1:0]  lin_addr;
	logic [AW-1:0]               stride;
	logic                        bad;
	logic [fblf_pkg::FW_W-1:0]   x0_e;
	logic [fblf_pkg::FW_W-1:0]   x1_e;
	logic [fblf_pkg::FH_W-1:0]   y0_e;
	logic [fblf_pkg::FH_W-1:0]   y1_e;
	logic                        ram_we;
	logic [AW-1:0]               ram_addr;
	logic [fblf_pkg::PIX_W-1:0]  ram_wdata;
	logic [fblf_pkg::PIX_W-1:0]  ram_rdata;

	// configuration registers keep the written bits (height only its low 10), clamping is applied on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= fblf_pkg::FW_RESET;
			fh_q <= fblf_pkg::FH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fblf_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_data;
				fblf_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_data[fblf_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fw_q == '0) eff_w = fblf_pkg::FW_W'(1);
		else if (32'(fw_q) > MAX_WIDTH) eff_w = fblf_pkg::FW_W'(MAX_WIDTH);
		else eff_w = fw_q;
		if (fh_q == '0) eff_h = fblf_pkg::FH_W'(1);
		else if (32'(fh_q) > MAX_HEIGHT) eff_h = fblf_pkg::FH_W'(MAX_HEIGHT);
		else eff_h = fh_q;
	end

	assign x0_e = fblf_pkg::FW_W'(req_q.x_first);
	assign x1_e = fblf_pkg::FW_W'(req_q.x_last);
	assign y0_e = fblf_pkg::FH_W'(req_q.y_first);
	assign y1_e = fblf_pkg::FH_W'(req_q.y_last);

	always_comb begin
		bad      = 1'b0;
		span_cnt = '0;
		case (req_q.req_type)
			fblf_pkg::REQ_WRITE, fblf_pkg::REQ_READ: begin
				bad = (x0_e >= eff_w) || (y0_e >= eff_h);
			end
			fblf_pkg::REQ_HFILL, fblf_pkg::REQ_HXOR: begin
				bad      = (req_q.x_first > req_q.x_last) || (x1_e >= eff_w) ||
				           (y0_e >= eff_h);
				span_cnt = req_q.x_last - req_q.x_first;
			end
			fblf_pkg::REQ_VFILL: begin
				bad      = (req_q.y_first > req_q.y_last) || (y1_e >= eff_h) ||
				           (x0_e >= eff_w);
				span_cnt = fblf_pkg::X_W'(req_q.y_last - req_q.y_first);
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	assign lin_addr = fblf_pkg::LIN_W'(req_q.y_first) * fblf_pkg::LIN_W'(eff_w) +
	                  fblf_pkg::LIN_W'(req_q.x_first);

	assign stride = (req_q.req_type == fblf_pkg::REQ_VFILL) ? AW'(eff_w) : AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.read_pixel <= '0;
		end else if (cmd.cap_rd) begin
			rsp_q.read_pixel <= ram_rdata;
		end
		if (cmd.calc) begin
			rsp_q.status <= bad;
			addr_q       <= AW'(lin_addr);
			cnt_q        <= span_cnt;
		end else if (cmd.step) begin
			addr_q <= addr_q + stride;
			cnt_q  <= cnt_q - fblf_pkg::X_W'(1);
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign ram_we    = cmd.clr | cmd.mem_we | cmd.xor_wr;
	assign ram_addr  = cmd.clr ? clr_addr_q : addr_q;
	assign ram_wdata = cmd.clr    ? '0 :
	                   cmd.xor_wr ? (ram_rdata ^ req_q.color) : req_q.color;

	fblf_ram #(
		.WIDTH(fblf_pkg::PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.re   (cmd.mem_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	assign sts.bad      = bad;
	assign sts.is_read  = (req_q.req_type == fblf_pkg::REQ_READ);
	assign sts.is_xor   = (req_q.req_type == fblf_pkg::REQ_HXOR);
	assign sts.last     = (cnt_q == '0);
	assign sts.clr_last = (clr_addr_q == AW'(DEPTH - 1));

	assign rsp = rsp_q;

endmodule
